// File: sv/ple_pkg.sv
package ple_pkg;

	localparam int POS_W      = 5;
	localparam int CMD_W      = 2;
	localparam int ST_W       = 2;
	localparam int WORD_W     = 32;
	localparam int CNT_OUT_W  = 5;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REPLACE  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             en;
		logic             ins;
		logic             del;
		logic             wr;
		logic             rd;
		logic [POS_W-1:0] pos;
	} ple_op_t;

endpackage

// File: sv/ple_req_if.sv
interface ple_req_if import ple_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [POS_W-1:0]  position;
	logic [WORD_W-1:0] entry_in;

	modport source (output valid, output cmd, output position, output entry_in, input ready);
	modport sink (input valid, input cmd, input position, input entry_in, output ready);
endinterface

// File: sv/ple_rsp_if.sv
interface ple_rsp_if import ple_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [WORD_W-1:0]    entry_out;
	logic [ST_W-1:0]      status;
	logic [CNT_OUT_W-1:0] item_count;
	logic                 is_empty;

	modport source (output valid, output entry_out, output status, output item_count,
		output is_empty, input ready);
	modport sink (input valid, input entry_out, input status, input item_count,
		input is_empty, output ready);
endinterface

// File: sv/ple_cell.sv
module ple_cell import ple_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  ple_op_t               op,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	input  logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] word,
	output logic [DATA_WIDTH-1:0] rd
);

	localparam int IW = (($clog2(DEPTH) > POS_W) ? $clog2(DEPTH) : POS_W) + 1;
	localparam logic [IW-1:0] IDX_V = IW'(IDX);

	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [IW-1:0]         pos_x;
	logic                  eq;
	logic                  gt;

	assign pos_x = IW'(op.pos);
	assign eq    = (IDX_V == pos_x);
	assign gt    = (IDX_V > pos_x);

	always_ff @(posedge clk) begin
		if (op.en) begin
			if (op.ins) begin
				if (gt) begin
					word_q <= left;
				end else if (eq) begin
					word_q <= data;
				end
			end else if (op.del) begin
				if (eq || gt) begin
					word_q <= right;
				end
			end else if (op.wr && eq) begin
				word_q <= data;
			end
			rd_q <= (op.rd && eq) ? word_q : '0;
		end
	end

	assign word = word_q;
	assign rd   = rd_q;

endmodule

// File: sv/positional_list_engine_core.sv
// Positional list engine: an ordered list of up to DEPTH words, head at position 0.
// Request channel (req): cmd, position, entry_in. Commands are insert, delete,
// retrieve and replace. Response channel (rsp): entry_out, status, item_count,
// is_empty; exactly one response per request, in request order.
// Each list slot is a cell in a chain; on insert or delete the cells from the position
// onward take the word of a neighbor, or on insert the new word, all in the same cycle.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while the response side keeps up; one
// response register sits between the sides and a new request is taken in the
// cycle its response is drained.
// Out-of-range positions and inserts into a full list return an error status
// and leave the list unchanged.
// Reset: the list is empty and no response is pending; slot contents are
// undefined until written and are never read before that.
// Receiver stall: the response holds and req.ready stays low until it is taken.
module positional_list_engine_core import ple_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]         cnt_q;
	logic [ST_W-1:0]       status_q;
	logic                  valid_q;
	logic                  accept;
	logic [ST_W-1:0]       st;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         cnt_x;
	ple_op_t               op;
	logic [DATA_WIDTH-1:0] data;
	logic [DATA_WIDTH-1:0] words [DEPTH];
	logic [DATA_WIDTH-1:0] rds   [DEPTH];
	logic [DATA_WIDTH-1:0] rd_or;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos_x     = XW'(req.position);
	assign cnt_x     = XW'(cnt_q);
	assign data      = DATA_WIDTH'(req.entry_in);

	always_comb begin
		st     = ST_OK;
		op     = '0;
		op.en  = accept;
		op.pos = req.position;
		unique case (req.cmd)
			CMD_INSERT: begin
				if (pos_x > cnt_x) begin
					st = ST_RANGE;
				end else if (cnt_q == FULL_CNT) begin
					st = ST_FULL;
				end else begin
					op.ins = accept;
				end
			end
			CMD_DELETE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					op.del = accept;
					op.rd  = accept;
				end
			end
			CMD_RETRIEVE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					op.rd = accept;
				end
			end
			CMD_REPLACE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					op.wr = accept;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ple_cell #(
			.DEPTH      (DEPTH),
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk   (clk),
			.op    (op),
			.left  (words[(i == 0) ? 0 : i - 1]),
			.right (words[(i == DEPTH - 1) ? i : i + 1]),
			.data  (data),
			.word  (words[i]),
			.rd    (rds[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rds[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_q  <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (accept) begin
				valid_q  <= 1'b1;
				status_q <= st;
				if (op.ins) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (op.del) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.entry_out  = WORD_W'(rd_or);
	assign rsp.status     = status_q;
	assign rsp.item_count = CNT_OUT_W'(cnt_q);
	assign rsp.is_empty   = (cnt_q == '0);

endmodule
